>>> rtl/tdsh_pkg.sv
// ----------------------------------------------------------------------------
// tdsh_pkg: shared types and constants of the table-driven string hash
// Generator constants, mixing-table geometry, state types and the
// constant-modulus reduction used while the table is filled.
// ----------------------------------------------------------------------------
package tdsh_pkg;

  localparam int HASH_TYPES  = 5;
  localparam int TABLE_WORDS = HASH_TYPES * 256;
  localparam int TABLE_AW    = $clog2(TABLE_WORDS);
  localparam int DIV_STEPS   = 32;
  localparam int DIV_CW      = $clog2(DIV_STEPS);

  localparam logic [21:0] GEN_START   = 22'h100001;
  localparam logic [6:0]  GEN_MUL     = 7'd125;
  localparam logic [28:0] GEN_ADD     = 29'd3;
  localparam logic [21:0] GEN_MOD     = 22'h2AAAAB;
  localparam logic [31:0] SEED_A_INIT = 32'h7FED7FED;
  localparam logic [31:0] SEED_B_INIT = 32'hEEEEEEEE;
  localparam logic [31:0] MIX_ADD     = 32'd3;
  localparam logic [16:0] BUCKET_RESET = 17'd1024;
  localparam logic [16:0] BUCKET_MAX  = 17'h10000;
  localparam logic        KIND_CHAR   = 1'b0;
  localparam logic        KIND_END    = 1'b1;

  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_CASE    = 8'h20;

  typedef enum logic [2:0] {
    FILL_MUL_HI,
    FILL_RED_HI,
    FILL_MUL_LO,
    FILL_RED_LO,
    FILL_DONE
  } fill_state_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_DIV,
    ST_OUT
  } tdsh_state_e;

  typedef struct packed {
    logic                en;
    logic [TABLE_AW-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] rem;
  } div_rsp_t;

  // x mod GEN_MOD for x below 2^29; GEN_MOD = (2^23 + 1) / 3, so the
  // quotient estimate 3x >> 23 is exact or one too high
  function automatic logic [21:0] gen_reduce(input logic [28:0] x);
    logic [30:0] x3;
    logic [7:0]  q;
    logic [29:0] prod;
    logic [30:0] r;
    x3   = {2'b00, x} * 31'd3;
    q    = x3[30:23];
    prod = {22'b0, q} * {8'b0, GEN_MOD};
    if ({1'b0, prod} > {2'b00, x}) begin
      r = {2'b00, x} + {9'b0, GEN_MOD} - {1'b0, prod};
    end else begin
      r = {2'b00, x} - {1'b0, prod};
    end
    return r[21:0];
  endfunction

endpackage

>>> rtl/table_driven_string_hash_unit.sv
// ----------------------------------------------------------------------------
// table_driven_string_hash_unit: table-driven string hash, one character
// per transaction
// After reset the 1280-word mixing table is filled from the generator,
// each word through FILL_MUL_HI, FILL_RED_HI, FILL_MUL_LO and FILL_RED_LO,
// and in_stall_o stays high until the fill is done. A character then goes
// through a registered table read, then the seed update. An end-of-string
// transaction waits for the bit-serial remainder unit (32 steps), unless
// the bucket count is zero. The output register lets a new transaction
// enter while a result still waits to be taken.
// ----------------------------------------------------------------------------
module table_driven_string_hash_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  char_code_i,
  input  logic [2:0]  hash_type_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o,
  output logic [15:0] bucket_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] cfg_data_i
);

  tdsh_pkg::tdsh_state_e state_q, state_d;
  logic [31:0] seed_a_q, seed_a_d;
  logic [31:0] seed_b_q, seed_b_d;
  logic [16:0] bucket_cnt_q;
  logic [7:0]  ch_q, ch_d;
  logic [31:0] hash_q, hash_d;
  logic [15:0] bkt_q, bkt_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_hash_q, out_hash_d;
  logic [15:0] out_bkt_q, out_bkt_d;

  logic                 table_ready;
  logic [31:0]          table_data;
  tdsh_pkg::tbl_rd_t    rd;
  tdsh_pkg::div_req_t   div_req;
  tdsh_pkg::div_rsp_t   div_rsp;
  logic                 in_accept;
  logic [7:0]           ch_up;
  logic [2:0]           type_sat;
  logic [16:0]          n_eff;
  logic [31:0]          mix_a;
  logic                 out_free;

  tdsh_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (rd),
    .rd_data_o (table_data),
    .ready_o   (table_ready)
  );

  tdsh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !(state_q == tdsh_pkg::ST_IDLE && table_ready);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // only a-z fold to upper case
  assign ch_up = (char_code_i >= tdsh_pkg::CH_LOWER_A && char_code_i <= tdsh_pkg::CH_LOWER_Z)
               ? char_code_i - tdsh_pkg::CH_CASE : char_code_i;
  assign type_sat = (hash_type_i >= 3'(tdsh_pkg::HASH_TYPES))
                  ? 3'(tdsh_pkg::HASH_TYPES - 1) : hash_type_i;
  assign n_eff = (bucket_cnt_q > tdsh_pkg::BUCKET_MAX) ? tdsh_pkg::BUCKET_MAX : bucket_cnt_q;

  assign rd.en   = in_accept && (kind_i == tdsh_pkg::KIND_CHAR);
  assign rd.addr = {type_sat, ch_up};

  assign div_req.start    = in_accept && (kind_i == tdsh_pkg::KIND_END) && (n_eff != '0);
  assign div_req.dividend = seed_a_q;
  assign div_req.divisor  = n_eff;

  assign mix_a = table_data ^ (seed_a_q + seed_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tdsh_pkg::ST_IDLE;
      seed_a_q     <= tdsh_pkg::SEED_A_INIT;
      seed_b_q     <= tdsh_pkg::SEED_B_INIT;
      bucket_cnt_q <= tdsh_pkg::BUCKET_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      seed_a_q    <= seed_a_d;
      seed_b_q    <= seed_b_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        bucket_cnt_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    hash_q     <= hash_d;
    bkt_q      <= bkt_d;
    out_hash_q <= out_hash_d;
    out_bkt_q  <= out_bkt_d;
  end

  always_comb begin
    state_d     = state_q;
    seed_a_d    = seed_a_q;
    seed_b_d    = seed_b_q;
    ch_d        = ch_q;
    hash_d      = hash_q;
    bkt_d       = bkt_q;
    out_hash_d  = out_hash_q;
    out_bkt_d   = out_bkt_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      tdsh_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (kind_i == tdsh_pkg::KIND_CHAR) begin
            ch_d    = ch_up;
            state_d = tdsh_pkg::ST_MIX;
          end else begin
            hash_d   = seed_a_q;
            bkt_d    = '0;
            seed_a_d = tdsh_pkg::SEED_A_INIT;
            seed_b_d = tdsh_pkg::SEED_B_INIT;
            state_d  = (n_eff == '0) ? tdsh_pkg::ST_OUT : tdsh_pkg::ST_DIV;
          end
        end
      end
      tdsh_pkg::ST_MIX: begin
        seed_a_d = mix_a;
        seed_b_d = {24'b0, ch_q} + mix_a + seed_b_q + {seed_b_q[26:0], 5'b0}
                 + tdsh_pkg::MIX_ADD;
        state_d  = tdsh_pkg::ST_IDLE;
      end
      tdsh_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          bkt_d   = div_rsp.rem;
          state_d = tdsh_pkg::ST_OUT;
        end
      end
      tdsh_pkg::ST_OUT: begin
        // hold until the output register can take the transaction
        if (out_free) begin
          out_hash_d  = hash_q;
          out_bkt_d   = bkt_q;
          out_valid_d = 1'b1;
          state_d     = tdsh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tdsh_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_hash_q;
  assign bucket_o     = out_bkt_q;

endmodule

>>> rtl/tdsh_table.sv
// ----------------------------------------------------------------------------
// tdsh_table: mixing table with its generator fill sequencer
// Fills the table from the congruential generator after reset, two draws
// per word, then serves registered reads.
// ----------------------------------------------------------------------------
module tdsh_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tdsh_pkg::tbl_rd_t             rd_i,
  output logic [31:0]                   rd_data_o,
  output logic                          ready_o
);

  logic [31:0] mem [tdsh_pkg::TABLE_WORDS];

  tdsh_pkg::fill_state_e state_q, state_d;
  logic [21:0] gen_q, gen_d;
  logic [28:0] prod_q, prod_d;
  logic [15:0] hi_q, hi_d;
  logic [2:0]  type_q, type_d;
  logic [7:0]  col_q, col_d;
  logic [21:0] red;
  logic        we;
  logic [31:0] rd_data_q;

  assign red = tdsh_pkg::gen_reduce(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdsh_pkg::FILL_MUL_HI;
      gen_q   <= tdsh_pkg::GEN_START;
      type_q  <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      gen_q   <= gen_d;
      type_q  <= type_d;
      col_q   <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    hi_q   <= hi_d;
  end

  always_comb begin
    state_d = state_q;
    gen_d   = gen_q;
    prod_d  = prod_q;
    hi_d    = hi_q;
    type_d  = type_q;
    col_d   = col_q;
    we      = 1'b0;
    unique case (state_q)
      tdsh_pkg::FILL_MUL_HI, tdsh_pkg::FILL_MUL_LO: begin
        prod_d  = {7'b0, gen_q} * {22'b0, tdsh_pkg::GEN_MUL} + tdsh_pkg::GEN_ADD;
        state_d = (state_q == tdsh_pkg::FILL_MUL_HI) ? tdsh_pkg::FILL_RED_HI
                                                     : tdsh_pkg::FILL_RED_LO;
      end
      tdsh_pkg::FILL_RED_HI: begin
        gen_d   = red;
        hi_d    = red[15:0];
        state_d = tdsh_pkg::FILL_MUL_LO;
      end
      tdsh_pkg::FILL_RED_LO: begin
        gen_d   = red;
        we      = 1'b1;
        state_d = tdsh_pkg::FILL_MUL_HI;
        // types run fastest, columns slowest
        if (type_q == 3'(tdsh_pkg::HASH_TYPES - 1)) begin
          type_d = '0;
          col_d  = col_q + 8'd1;
          if (col_q == 8'hFF) begin
            state_d = tdsh_pkg::FILL_DONE;
          end
        end else begin
          type_d = type_q + 3'd1;
        end
      end
      tdsh_pkg::FILL_DONE: begin
        state_d = tdsh_pkg::FILL_DONE;
      end
      default: begin
        state_d = tdsh_pkg::FILL_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[{type_q, col_q}] <= {hi_q, red[15:0]};
    end
    if (rd_i.en) begin
      rd_data_q <= mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = (state_q == tdsh_pkg::FILL_DONE);

endmodule

>>> rtl/tdsh_div.sv
// ----------------------------------------------------------------------------
// tdsh_div: bit-serial remainder unit
// Restoring division of a 32-bit hash by a bucket count, one quotient bit
// per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module tdsh_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tdsh_pkg::div_req_t req_i,
  output tdsh_pkg::div_rsp_t rsp_o
);

  logic                        busy_q, busy_d;
  logic [tdsh_pkg::DIV_CW-1:0] cnt_q, cnt_d;
  logic [31:0]                 dvd_q, dvd_d;
  logic [16:0]                 dvs_q, dvs_d;
  logic [16:0]                 rem_q, rem_d;
  logic [17:0]                 shifted;
  logic                        done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    done    = 1'b0;
    shifted = {rem_q, dvd_q[31]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = 17'(shifted - {1'b0, dvs_q});
      end else begin
        rem_d = shifted[16:0];
      end
      dvd_d = {dvd_q[30:0], 1'b0};
      cnt_d = cnt_q + tdsh_pkg::DIV_CW'(1);
      if (cnt_q == tdsh_pkg::DIV_CW'(tdsh_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done   = 1'b1;
      end
    end
  end

  assign rsp_o.done = done;
  assign rsp_o.rem  = rem_d[15:0];

endmodule

>>> tb/tdsh_digest_check.sv
// ----------------------------------------------------------------------------
// tdsh_digest_check: result checker for the table-driven string hash unit
// Watches the character, result and bucket-count channels, folds every
// accepted character into its own copy of the running seeds, queues the
// hash and bucket expected for each end-of-string transaction and compares
// them field by field with the results the unit hands out.
// ----------------------------------------------------------------------------
module tdsh_digest_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        kind_i,
  input  logic [7:0]  char_code_i,
  input  logic [2:0]  hash_type_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] hash_value_i,
  input  logic [15:0] bucket_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [16:0] cfg_data_i,
  output int          fault_count_o,
  output int          digests_due_o
);

  typedef struct packed {
    logic [31:0] hash;
    logic [15:0] bucket;
  } digest_t;

  logic [31:0] mix_words [tdsh_pkg::TABLE_WORDS];
  logic [31:0] seed_a;
  logic [31:0] seed_b;
  logic [16:0] bucket_count;
  digest_t     digests_due [$];

  // same generator walk as the fill after reset: column-major, two draws a word
  initial begin : build_mix_words
    int unsigned lcg;
    logic [15:0] upper;
    lcg = tdsh_pkg::GEN_START;
    for (int col = 0; col < 256; col++) begin
      for (int sect = 0; sect < tdsh_pkg::HASH_TYPES; sect++) begin
        lcg   = (lcg * 32'd125 + 32'd3) % tdsh_pkg::GEN_MOD;
        upper = 16'(lcg & 32'hFFFF);
        lcg   = (lcg * 32'd125 + 32'd3) % tdsh_pkg::GEN_MOD;
        mix_words[sect * 256 + col] = {upper, 16'(lcg & 32'hFFFF)};
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [7:0]  ch;
    logic [31:0] mixed;
    logic [16:0] span;
    int          sect;
    digest_t     want;
    if (!rst_ni) begin
      seed_a        = tdsh_pkg::SEED_A_INIT;
      seed_b        = tdsh_pkg::SEED_B_INIT;
      bucket_count  = tdsh_pkg::BUCKET_RESET;
      fault_count_o = 0;
      digests_due.delete();
      digests_due_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (digests_due.size() == 0) begin
          fault_count_o++;
          $error("result transaction with no string pending: hash_value %h bucket %h",
                 hash_value_i, bucket_i);
        end else begin
          want = digests_due.pop_front();
          if (hash_value_i !== want.hash) begin
            fault_count_o++;
            $error("hash_value: expected %h, actual %h", want.hash, hash_value_i);
          end
          if (bucket_i !== want.bucket) begin
            fault_count_o++;
            $error("bucket: expected %h, actual %h", want.bucket, bucket_i);
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (kind_i == tdsh_pkg::KIND_CHAR) begin
          ch = char_code_i;
          if (ch >= tdsh_pkg::CH_LOWER_A && ch <= tdsh_pkg::CH_LOWER_Z) begin
            ch = ch - tdsh_pkg::CH_CASE;
          end
          // out-of-range types fall onto the last table section
          sect   = (hash_type_i >= tdsh_pkg::HASH_TYPES) ? tdsh_pkg::HASH_TYPES - 1
                                                         : int'(hash_type_i);
          mixed  = mix_words[sect * 256 + ch] ^ (seed_a + seed_b);
          seed_b = {24'b0, ch} + mixed + seed_b + (seed_b << 5) + tdsh_pkg::MIX_ADD;
          seed_a = mixed;
        end else begin
          span      = (bucket_count > tdsh_pkg::BUCKET_MAX) ? tdsh_pkg::BUCKET_MAX
                                                            : bucket_count;
          want.hash = seed_a;
          want.bucket = (span == 0) ? 16'h0 : 16'(seed_a % span);
          digests_due.push_back(want);
          seed_a = tdsh_pkg::SEED_A_INIT;
          seed_b = tdsh_pkg::SEED_B_INIT;
        end
      end

      // a write takes effect after the edge it lands on
      if (cfg_valid_i && cfg_ready_i) begin
        bucket_count = cfg_data_i;
      end
      digests_due_o <= digests_due.size();
    end
  end

endmodule

>>> tb/tb_table_driven_string_hash_unit.sv
// ----------------------------------------------------------------------------
// tb_table_driven_string_hash_unit: testbench of the table-driven string hash
// Waits out the table fill, sends a short directed set of strings (empty
// string, case folding edges, zero and high bytes, every hash type), then
// random strings under several bucket counts from zero past the maximum,
// with random gaps and result stalls. A separate checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb_table_driven_string_hash_unit;

  localparam int   IDLE_PCT     = 17;
  localparam int   PHASE_ITEMS  = 236;
  localparam int   PHASES       = 7;
  localparam int   DRAIN_CYCLES = 60;
  localparam logic KIND_TXT     = tdsh_pkg::KIND_CHAR;
  localparam logic KIND_END     = tdsh_pkg::KIND_END;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        kind_i;
  logic [7:0]  char_code_i;
  logic [2:0]  hash_type_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] hash_value_o;
  logic [15:0] bucket_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [16:0] cfg_data_i;

  int fault_count;
  int digests_due;
  bit steady;
  int strings_sent;
  int chars_sent;
  int settings_used;

  table_driven_string_hash_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .char_code_i (char_code_i),
    .hash_type_i (hash_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hash_value_o(hash_value_o),
    .bucket_o    (bucket_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  tdsh_digest_check u_digest_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .kind_i       (kind_i),
    .char_code_i  (char_code_i),
    .hash_type_i  (hash_type_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_i (hash_value_o),
    .bucket_i     (bucket_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fault_count_o(fault_count),
    .digests_due_o(digests_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99, 0) < IDLE_PCT);
  end

  // allows for the table fill plus every transaction
  initial begin
    #5_000_000;
    $display("table_driven_string_hash_unit: mismatch");
    $finish;
  end

  task automatic send_item(input logic kind, input logic [7:0] code, input logic [2:0] sect);
    while (!steady && $urandom_range(99, 0) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    char_code_i <= code;
    hash_type_i <= sect;
    do @(posedge clk_i); while (in_stall_o);
    if (kind == KIND_END) strings_sent++;
    else chars_sent++;
  endtask

  // mostly letters of both cases, a type that now and then changes mid-string
  task automatic send_string(input int len, input logic [2:0] sect);
    int          pick;
    logic [7:0]  code;
    logic [2:0]  ty;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 50) code = tdsh_pkg::CH_LOWER_A + 8'($urandom_range(25, 0));
      else if (pick < 70) begin
        code = tdsh_pkg::CH_LOWER_A - tdsh_pkg::CH_CASE + 8'($urandom_range(25, 0));
      end
      else code = 8'($urandom_range(255, 0));
      ty = ($urandom_range(99, 0) < 10) ? 3'($urandom_range(7, 0)) : sect;
      send_item(KIND_TXT, code, ty);
    end
    send_item(KIND_END, 8'($urandom_range(255, 0)), 3'($urandom_range(7, 0)));
  endtask

  task automatic write_buckets(input logic [16:0] count);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // hold off until every hash is back and the divider has surely finished
  task automatic drain_hashes();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (digests_due != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [16:0] bucket_plan [PHASES];
    int          start_items;
    int          len;
    logic [2:0]  sect;
    in_valid_i  <= 1'b0;
    kind_i      <= KIND_TXT;
    char_code_i <= 8'h00;
    hash_type_i <= 3'd0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= 17'h0;
    rst_ni      <= 1'b0;
    steady       = 1'b0;
    bucket_plan = '{17'h1FFFF, 17'h0, 17'h1, tdsh_pkg::BUCKET_MAX, 17'hFFFF,
                    17'($urandom_range(65534, 2)), 17'($urandom_range(131070, 65537))};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed strings under the reset bucket count
    send_item(KIND_END, 8'h00, 3'd0);
    send_item(KIND_TXT, tdsh_pkg::CH_LOWER_A, 3'd0);
    send_item(KIND_TXT, tdsh_pkg::CH_LOWER_Z, 3'd1);
    send_item(KIND_TXT, 8'h41, 3'd2);
    send_item(KIND_TXT, 8'h5A, 3'd3);
    send_item(KIND_TXT, 8'h60, 3'd4);
    send_item(KIND_TXT, 8'h7B, 3'd5);
    send_item(KIND_END, 8'h7B, 3'd5);
    send_item(KIND_TXT, 8'h00, 3'd6);
    send_item(KIND_TXT, 8'hFF, 3'd7);
    send_item(KIND_TXT, 8'h80, 3'd0);
    send_item(KIND_END, 8'hFF, 3'd7);
    // lower and upper case spellings must hash alike
    send_item(KIND_TXT, 8'h61, 3'd2);
    send_item(KIND_TXT, 8'h62, 3'd2);
    send_item(KIND_END, 8'h00, 3'd2);
    send_item(KIND_TXT, 8'h41, 3'd2);
    send_item(KIND_TXT, 8'h42, 3'd2);
    send_item(KIND_END, 8'h00, 3'd2);
    send_item(KIND_END, 8'hAA, 3'd4);

    for (int p = 0; p < PHASES; p++) begin
      drain_hashes();
      write_buckets(bucket_plan[p]);
      steady      = (p == 2);
      start_items = strings_sent + chars_sent;
      while (strings_sent + chars_sent - start_items < PHASE_ITEMS) begin
        len  = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 0);
        sect = ($urandom_range(99, 0) < 85) ? 3'($urandom_range(4, 0))
                                            : 3'($urandom_range(7, 5));
        send_string(len, sect);
      end
    end
    steady = 1'b0;
    drain_hashes();

    $display("hashed %0d strings built from %0d characters, all eight hash type codes,",
             strings_sent, chars_sent);
    $display("under %0d bucket count settings besides reset, from zero to beyond 65536",
             settings_used);
    if (fault_count == 0 && digests_due == 0) begin
      $display("table_driven_string_hash_unit: match");
    end else begin
      $display("table_driven_string_hash_unit: mismatch");
    end
    $finish;
  end

endmodule
